@@ hdl/ssme_pkg.sv @@
package ssme_pkg;

    localparam int KEY_W       = 16;
    localparam int SLOT_W      = 12;
    localparam int BIDX_W      = 7;
    localparam int BLK_W       = 6;
    localparam int OFF_W       = 6;
    localparam int BLOCK_SIZE  = 64;
    localparam int BLOCK_COUNT = 64;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 8;

    // descent probe counts and per-bank depths of the last-key copies
    localparam int L1_PROBES   = 3;
    localparam int L2_PROBES   = 3;
    localparam int L3_PROBES   = 4;
    localparam int L2_DEPTH    = 4;
    localparam int L3_DEPTH    = 16;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [OFF_W-1:0]  OFF_FIRST  = '0;
    localparam logic [OFF_W-1:0]  OFF_LAST   = '1;
    localparam logic [BIDX_W-1:0] BIDX_ABOVE = BIDX_W'(BLOCK_COUNT);

    typedef struct packed {
        logic              valid;
        logic              act;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  value;
    } t_item;

    typedef struct packed {
        logic              valid;
        logic              found;
        logic [BIDX_W-1:0] bidx;
    } t_result;

endpackage

@@ hdl/ssme_ram.sv @@
module ssme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/ssme_descent.sv @@
module ssme_descent import ssme_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  t_item             i_item,
    output t_item             o_item,
    output logic [BIDX_W-1:0] o_lo
);

    // stage A: fixed probes 16/32/48, issue second-level reads
    logic [BLK_W-1:0] w_a_blk;
    logic             w_a_last_wr;
    logic [1:0]       w_c1;
    logic [KEY_W-1:0] r_l1 [L1_PROBES];
    logic [KEY_W-1:0] w_l2_q [L2_PROBES];

    assign w_a_blk     = i_item.slot[SLOT_W-1 -: BLK_W];
    assign w_a_last_wr = i_adv && i_item.valid && (i_item.act == ACT_LOAD)
                         && (i_item.slot[OFF_W-1:0] == OFF_LAST);

    always_ff @(posedge i_clk) begin
        if (w_a_last_wr && (w_a_blk[3:0] == 4'd0) && (w_a_blk[5:4] != 2'd0)) begin
            r_l1[w_a_blk[5:4] - 2'd1] <= i_item.value;
        end
    end

    always_comb begin
        w_c1 = '0;
        for (int j = 0; j < L1_PROBES; j++) begin
            w_c1 = w_c1 + 2'(r_l1[j] < i_item.value);
        end
    end

    // second level: entries 16*k + 4*(g+1)
    for (genvar g = 0; g < L2_PROBES; g++) begin : g_l2
        ssme_ram #(.WIDTH(KEY_W), .DEPTH(L2_DEPTH)) u_l2 (
            .i_clk   (i_clk),
            .i_we    (w_a_last_wr && (w_a_blk[1:0] == 2'd0) && (w_a_blk[3:2] == 2'(g + 1))),
            .i_waddr (w_a_blk[5:4]),
            .i_wdata (i_item.value),
            .i_re    (i_adv),
            .i_raddr (w_c1),
            .o_rdata (w_l2_q[g])
        );
    end

    // stage B
    t_item            r_b_item;
    logic [BLK_W-1:0] r_b_base1;
    logic [BLK_W-1:0] w_b_blk;
    logic             w_b_last_wr;
    logic [1:0]       w_c2;
    logic [BLK_W-1:0] w_b_base2;
    logic [KEY_W-1:0] w_l3_q [L3_PROBES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_item.valid <= 1'b0;
        end else if (i_adv) begin
            r_b_item  <= i_item;
            r_b_base1 <= {w_c1, 4'd0};
        end
    end

    assign w_b_blk     = r_b_item.slot[SLOT_W-1 -: BLK_W];
    assign w_b_last_wr = i_adv && r_b_item.valid && (r_b_item.act == ACT_LOAD)
                         && (r_b_item.slot[OFF_W-1:0] == OFF_LAST);

    always_comb begin
        w_c2 = '0;
        for (int j = 0; j < L2_PROBES; j++) begin
            w_c2 = w_c2 + 2'(w_l2_q[j] < r_b_item.value);
        end
    end

    assign w_b_base2 = r_b_base1 + BLK_W'({w_c2, 2'd0});

    // third level: four banks by entry index mod 4
    for (genvar g = 0; g < L3_PROBES; g++) begin : g_l3
        ssme_ram #(.WIDTH(KEY_W), .DEPTH(L3_DEPTH)) u_l3 (
            .i_clk   (i_clk),
            .i_we    (w_b_last_wr && (w_b_blk[1:0] == 2'(g))),
            .i_waddr (w_b_blk[5:2]),
            .i_wdata (r_b_item.value),
            .i_re    (i_adv),
            .i_raddr (w_b_base2[5:2]),
            .o_rdata (w_l3_q[g])
        );
    end

    // stage C
    t_item            r_c_item;
    logic [BLK_W-1:0] r_c_base2;
    logic [2:0]       w_c3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_item.valid <= 1'b0;
        end else if (i_adv) begin
            r_c_item  <= r_b_item;
            r_c_base2 <= w_b_base2;
        end
    end

    always_comb begin
        w_c3 = '0;
        for (int j = 0; j < L3_PROBES; j++) begin
            w_c3 = w_c3 + 3'(w_l3_q[j] < r_c_item.value);
        end
    end

    assign o_lo   = {1'b0, r_c_base2} + BIDX_W'(w_c3);
    assign o_item = r_c_item;

`ifndef SYNTHESIS
    a_lo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_item.valid && (r_c_item.act == ACT_QUERY)) |-> (o_lo <= BIDX_ABOVE))
        else $error("descent result above block count");
`endif

endmodule

@@ hdl/ssme_block_match.sv @@
module ssme_block_match import ssme_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  t_item             i_item,
    input  logic [BIDX_W-1:0] i_lo,
    output t_result           o_res
);

    logic [BLK_W-1:0] w_blk;
    logic [OFF_W-1:0] w_off;
    logic             w_load_wr;
    logic [KEY_W-1:0] w_first_q;
    logic [KEY_W-1:0] w_lane_q [BLOCK_SIZE];

    assign w_blk     = i_item.slot[SLOT_W-1 -: BLK_W];
    assign w_off     = i_item.slot[OFF_W-1:0];
    assign w_load_wr = i_adv && i_item.valid && (i_item.act == ACT_LOAD);

    ssme_ram #(.WIDTH(KEY_W), .DEPTH(BLOCK_COUNT)) u_first (
        .i_clk   (i_clk),
        .i_we    (w_load_wr && (w_off == OFF_FIRST)),
        .i_waddr (w_blk),
        .i_wdata (i_item.value),
        .i_re    (i_adv),
        .i_raddr (i_lo[BLK_W-1:0]),
        .o_rdata (w_first_q)
    );

    // one bank per key offset, a whole block is read in one access
    for (genvar g = 0; g < BLOCK_SIZE; g++) begin : g_lane
        ssme_ram #(.WIDTH(KEY_W), .DEPTH(BLOCK_COUNT)) u_lane (
            .i_clk   (i_clk),
            .i_we    (w_load_wr && (w_off == OFF_W'(g))),
            .i_waddr (w_blk),
            .i_wdata (i_item.value),
            .i_re    (i_adv),
            .i_raddr (i_lo[BLK_W-1:0]),
            .o_rdata (w_lane_q[g])
        );
    end

    // stage D
    logic              r_d_valid;
    logic              r_d_act;
    logic [KEY_W-1:0]  r_d_value;
    logic [BIDX_W-1:0] r_d_lo;
    logic [BLOCK_SIZE-1:0] w_eq;
    logic              w_found;
    t_result           r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (i_adv) begin
            r_d_valid <= i_item.valid;
            r_d_act   <= i_item.act;
            r_d_value <= i_item.value;
            r_d_lo    <= i_lo;
        end
    end

    always_comb begin
        for (int j = 0; j < BLOCK_SIZE; j++) begin
            w_eq[j] = (w_lane_q[j] == r_d_value);
        end
    end

    // lo never exceeds the block count, so its top bit marks "above all blocks"
    assign w_found = (r_d_act == ACT_QUERY) && !r_d_lo[BIDX_W-1]
                     && (r_d_value >= w_first_q) && (|w_eq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.valid <= 1'b0;
        end else if (i_adv) begin
            r_res.valid <= r_d_valid;
            r_res.found <= w_found;
            r_res.bidx  <= (r_d_act == ACT_QUERY) ? r_d_lo : '0;
        end
    end

    assign o_res = r_res;

`ifndef SYNTHESIS
    a_found_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res.valid && r_res.found) |-> (r_res.bidx < BIDX_ABOVE))
        else $error("hit reported above last block");

    a_load_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && r_d_valid && (r_d_act == ACT_LOAD))
        |=> (r_res.valid && !r_res.found && (r_res.bidx == '0)))
        else $error("load word produced nonzero result");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_res.valid && !r_d_valid))
        else $error("valid bits not cleared by reset");
`endif

endmodule

@@ hdl/sorted_set_membership_engine.sv @@
// Sorted-set membership lookup over 64 blocks of 64 sixteen-bit keys.
// Input stream: s_axis_tuser is the action (0 = load key, 1 = query);
// s_axis_tdata carries slot and key. Load words write the key at its slot,
// and at a block's first or last slot also the block's first or last key.
// Query words return found and the block index from the last-key descent.
// Every input word gives exactly one output word on m_axis, in order;
// load words answer found = 0, block index = 0.
// One word is accepted per cycle unless stalled. The pipeline has four register stages:
// three descent levels over banked copies of the last-key index, then the
// 64-lane compare of the selected block, whose banks are read in one access.
// A result passes the B, C, D and result registers before it is presented on m_axis.
// When the output word waits and m_axis_tready is low, all stages hold and
// s_axis_tready drops; nothing is lost or repeated.
// Reset clears the valid bits only; key storage is undefined until loaded,
// and queries are meaningful only after a complete sorted load.
module sorted_set_membership_engine import ssme_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // slot[11:0], key_value[27:12], zero pad
    input  logic                   s_axis_tuser,   // action
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // found[0], block_index[7:1]
);

    logic              w_adv;
    t_item             w_in_item;
    t_item             w_c_item;
    logic [BIDX_W-1:0] w_c_lo;
    t_result           w_res;

    assign w_adv = !w_res.valid || m_axis_tready;

    assign w_in_item = '{
        valid: s_axis_tvalid,
        act:   s_axis_tuser,
        slot:  s_axis_tdata[SLOT_W-1:0],
        value: s_axis_tdata[SLOT_W +: KEY_W]
    };

    ssme_descent u_descent (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_item  (w_in_item),
        .o_item  (w_c_item),
        .o_lo    (w_c_lo)
    );

    ssme_block_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_item  (w_c_item),
        .i_lo    (w_c_lo),
        .o_res   (w_res)
    );

    assign s_axis_tready = w_adv;
    assign m_axis_tvalid = w_res.valid;
    assign m_axis_tdata  = {w_res.bidx, w_res.found};

endmodule
